// ===== rtl/scpf_pkg.sv =====
package scpf_pkg;

  // action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  // command kinds
  localparam logic [1:0] KIND_OTHER   = 2'd0;
  localparam logic [1:0] KIND_AVOID   = 2'd1;
  localparam logic [1:0] KIND_PARKING = 2'd2;

  localparam int unsigned PKT_MAX = 4;

  // byte values
  localparam logic [7:0] RAW_AVOID   = 8'h01;
  localparam logic [7:0] RAW_PARKING = 8'h02;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_1      = 8'h31;
  localparam logic [7:0] CHAR_2      = 8'h32;
  localparam logic [7:0] CHAR_X_LO   = 8'h78;
  localparam logic [7:0] CHAR_X_UP   = 8'h58;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_data;
  } scpf_in_t;

  typedef struct packed {
    logic       packet_valid;
    logic [2:0] packet_length;
    logic [1:0] command_kind;
  } scpf_out_t;

endpackage

// ===== rtl/serial_command_packet_framer_top.sv =====
// Serial command packet framer. Each item on the cmd channel is either a
// received byte (action 0) or a poll (action 1). Bytes build a packet of up
// to four bytes: a raw 0x01 or 0x02 byte is a whole packet by itself, CR or
// LF closes a non-empty packet, and "01", "02" or four characters complete
// one; bytes arriving while a finished packet waits are dropped. Every poll
// gives exactly one item on the res channel: the waiting packet's length and
// kind (avoid for 0x01/"01"/"0x01", parking for 0x02/"02"/"0x02", upper- or
// lower-case x, else other), or an all-zero item when nothing waits. Bytes
// give no result. One item is taken per clock cycle while cmd_ready is high;
// the framing state is updated in the cycle of acceptance. A poll's result
// goes to the result register on the output, or to the one skid register
// behind it while the result register holds a result not yet taken, so
// cmd_ready only drops when two results are held back by res_ready low.
module serial_command_packet_framer_top
  import scpf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  scpf_in_t  cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output scpf_out_t res
);

  // framing state
  logic [7:0] packet_bytes [PKT_MAX];
  logic [7:0] packet_bytes_next [PKT_MAX];
  logic [2:0] byte_count, byte_count_next;
  logic       packet_waiting, packet_waiting_next;

  // output register and skid stage
  scpf_out_t  out_reg, skid_reg;
  logic       out_valid, skid_valid;

  logic       cmd_fire, push, pop;
  scpf_out_t  result;

  assign cmd_ready = !skid_valid;
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign push      = cmd_fire && (cmd.action == ACT_POLL);
  assign pop       = out_valid && res_ready;
  assign res_valid = out_valid;
  assign res       = out_reg;

  // kind of the packet currently held
  logic [1:0] kind;
  always_comb begin
    kind = KIND_OTHER;
    if (byte_count == 3'd1) begin
      if (packet_bytes[0] == RAW_AVOID)        kind = KIND_AVOID;
      else if (packet_bytes[0] == RAW_PARKING) kind = KIND_PARKING;
    end else if (byte_count == 3'd2 && packet_bytes[0] == CHAR_0) begin
      if (packet_bytes[1] == CHAR_1)      kind = KIND_AVOID;
      else if (packet_bytes[1] == CHAR_2) kind = KIND_PARKING;
    end else if (byte_count == 3'd4 && packet_bytes[0] == CHAR_0 &&
                 (packet_bytes[1] == CHAR_X_LO || packet_bytes[1] == CHAR_X_UP) &&
                 packet_bytes[2] == CHAR_0) begin
      if (packet_bytes[3] == CHAR_1)      kind = KIND_AVOID;
      else if (packet_bytes[3] == CHAR_2) kind = KIND_PARKING;
    end
  end

  // poll result: all zero when nothing waits
  always_comb begin
    result = '0;
    if (packet_waiting) begin
      result.packet_valid  = 1'b1;
      result.packet_length = byte_count;
      result.command_kind  = kind;
    end
  end

  // framing next state
  logic [7:0] d;
  logic [2:0] base_count;
  logic [1:0] idx;
  assign d = cmd.rx_data;

  always_comb begin
    packet_bytes_next   = packet_bytes;
    byte_count_next     = byte_count;
    packet_waiting_next = packet_waiting;
    base_count          = byte_count;
    idx                 = byte_count[1:0];
    if (cmd_fire) begin
      if (cmd.action == ACT_POLL) begin
        if (packet_waiting) begin
          // fetch clears the packet
          for (int i = 0; i < PKT_MAX; i++) packet_bytes_next[i] = '0;
          byte_count_next     = '0;
          packet_waiting_next = 1'b0;
        end
      end else if (!packet_waiting) begin
        if (d == RAW_AVOID || d == RAW_PARKING) begin
          // raw command byte replaces any partial packet
          for (int i = 0; i < PKT_MAX; i++) packet_bytes_next[i] = '0;
          packet_bytes_next[0] = d;
          byte_count_next      = 3'd1;
          packet_waiting_next  = 1'b1;
        end else if (d == CHAR_CR || d == CHAR_LF) begin
          if (byte_count != 3'd0) packet_waiting_next = 1'b1;
        end else begin
          // full packet never sits here unwaited; kept for safety
          if (byte_count[2]) begin
            for (int i = 0; i < PKT_MAX; i++) packet_bytes_next[i] = '0;
            base_count = '0;
          end
          idx = base_count[1:0];
          packet_bytes_next[idx] = d;
          byte_count_next        = base_count + 3'd1;
          if (byte_count_next[2] ||
              (byte_count_next >= 3'd2 && packet_bytes_next[0] == CHAR_0 &&
               (packet_bytes_next[1] == CHAR_1 || packet_bytes_next[1] == CHAR_2)))
            packet_waiting_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PKT_MAX; i++) packet_bytes[i] <= '0;
      byte_count     <= '0;
      packet_waiting <= 1'b0;
    end else begin
      packet_bytes   <= packet_bytes_next;
      byte_count     <= byte_count_next;
      packet_waiting <= packet_waiting_next;
    end
  end

  // result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_reg <= skid_reg;
    end else if (push) begin
      if (out_valid && !pop) skid_reg <= result;
      else                   out_reg  <= result;
    end
  end

endmodule

// ===== rtl/scpf_checker.sv =====
module scpf_checker
  import scpf_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_ready,
  input scpf_in_t  cmd,
  input logic      res_valid,
  input logic      res_ready,
  input scpf_out_t res
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // empty poll is all zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.packet_valid |->
      res.packet_length == 3'd0 && res.command_kind == KIND_OTHER)
    else $error("empty poll not zero");

  // fetched packet has one to four bytes
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.packet_valid |->
      res.packet_length != 3'd0 && res.packet_length <= 3'd4)
    else $error("bad packet length");

  // recognised commands are one, two or four bytes long
  a_kind_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.command_kind == KIND_AVOID || res.command_kind == KIND_PARKING) |->
      res.packet_length == 3'd1 || res.packet_length == 3'd2 || res.packet_length == 3'd4)
    else $error("command kind with wrong length");

  // no unused kind code
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.command_kind == KIND_OTHER || res.command_kind == KIND_AVOID ||
                  res.command_kind == KIND_PARKING)
    else $error("unused kind code");

endmodule

bind serial_command_packet_framer_top scpf_checker u_scpf_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
